>>> hw/rtl/unv_pkg.sv
package unv_pkg;

   localparam int ByteTotalWidth = 8;
   localparam int PointWidth = 6;
   localparam int CodePointWidth = 21;
   localparam int BufferBytesDefault = 128;
   localparam logic [PointWidth-1:0] MaxPointsReset = 6'd24;

   // Report codes; Ready doubles as "no error recorded yet" in the state
   typedef enum logic [2:0] {
      StReady          = 3'd0,
      StTooLong        = 3'd1,
      StInvalidUtf8    = 3'd2,
      StNeedsNormalize = 3'd3,
      StUnsupported    = 3'd4,
      StInvalidSpacing = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] byte_req;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      status_type            status;
      logic [PointWidth-1:0] code_points;
   } rsp_payload_type;

   typedef struct packed {
      logic [ByteTotalWidth-1:0] byte_total;
      logic [PointWidth-1:0]     point_total;
      logic [CodePointWidth-1:0] partial_point;
      logic [1:0]                bytes_pending;
      logic [1:0]                lower_bound_sel;
      logic                      last_was_space;
      status_type                first_error;
   } name_state_type;

   localparam name_state_type StateReset = '{
      byte_total:      '0,
      point_total:     '0,
      partial_point:   '0,
      bytes_pending:   2'd0,
      lower_bound_sel: 2'd0,
      last_was_space:  1'b1,
      first_error:     StReady
   };

endpackage

>>> hw/rtl/unv_decode.sv
module unv_decode
   import unv_pkg::*;
#(
   parameter int BUFFER_BYTES = BufferBytesDefault
) (
   input  name_state_type        cur_state,
   input  req_payload_type       beat,
   input  logic [PointWidth-1:0] max_code_points,
   output name_state_type        next_state,
   output rsp_payload_type       result
);

   localparam logic [ByteTotalWidth-1:0] ByteLimit = ByteTotalWidth'(BUFFER_BYTES);

   logic [7:0]                b;
   logic                      do_finish;
   logic [CodePointWidth-1:0] cp;
   logic [CodePointWidth-1:0] minimum;
   logic [1:0]                bound_sel;
   logic                      allowed;
   name_state_type            upd;

   assign b = beat.byte_req;

   always_comb begin
      allowed = ((cp >= 21'h41) && (cp <= 21'h5a)) || ((cp >= 21'h61) && (cp <= 21'h7a)) ||
                ((cp >= 21'h30) && (cp <= 21'h39)) || (cp == 21'h20) || (cp == 21'h2d) ||
                (cp == 21'h27) || ((cp >= 21'hc0) && (cp <= 21'hd6)) ||
                ((cp >= 21'hd8) && (cp <= 21'hf6)) || ((cp >= 21'hf8) && (cp <= 21'hff));
   end

   always_comb begin
      upd       = cur_state;
      do_finish = 1'b0;
      cp        = '0;
      bound_sel = 2'd0;
      minimum   = '0;

      if (cur_state.byte_total != {ByteTotalWidth{1'b1}}) begin
         upd.byte_total = cur_state.byte_total + 1'b1;
      end

      // Decode only until the first error is recorded
      if (cur_state.first_error == StReady) begin
         if (cur_state.bytes_pending == 2'd0) begin
            if (b < 8'h80) begin
               do_finish = 1'b1;
               cp        = {13'd0, b};
            end else if (b inside {[8'hc2:8'hdf]}) begin
               upd.partial_point   = {16'd0, b[4:0]};
               upd.bytes_pending   = 2'd1;
               upd.lower_bound_sel = 2'd1;
            end else if (b inside {[8'he0:8'hef]}) begin
               upd.partial_point   = {17'd0, b[3:0]};
               upd.bytes_pending   = 2'd2;
               upd.lower_bound_sel = 2'd2;
            end else if (b inside {[8'hf0:8'hf4]}) begin
               upd.partial_point   = {18'd0, b[2:0]};
               upd.bytes_pending   = 2'd3;
               upd.lower_bound_sel = 2'd3;
            end else begin
               upd.first_error = StInvalidUtf8;
            end
         end else if (b[7:6] != 2'b10) begin
            upd.first_error = StInvalidUtf8;
         end else begin
            upd.partial_point = {cur_state.partial_point[CodePointWidth-7:0], b[5:0]};
            upd.bytes_pending = cur_state.bytes_pending - 2'd1;
            if (cur_state.bytes_pending == 2'd1) begin
               do_finish = 1'b1;
               cp        = upd.partial_point;
               bound_sel = cur_state.lower_bound_sel;
            end
         end
      end

      case (bound_sel)
         2'd1:    minimum = 21'h80;
         2'd2:    minimum = 21'h800;
         2'd3:    minimum = 21'h10000;
         default: minimum = '0;
      endcase

      if (do_finish) begin
         upd.lower_bound_sel = 2'd0;
         if ((cp < minimum) || (cp > 21'h10ffff) || ((cp >= 21'hd800) && (cp <= 21'hdfff))) begin
            upd.first_error = StInvalidUtf8;
         end else if (cur_state.point_total >= max_code_points) begin
            upd.first_error = StTooLong;
         end else begin
            upd.point_total = cur_state.point_total + 1'b1;
            if ((cp >= 21'h300) && (cp <= 21'h36f)) begin
               upd.first_error = StNeedsNormalize;
            end else if (!allowed) begin
               upd.first_error = StUnsupported;
            end else if ((cp == 21'h20) && cur_state.last_was_space) begin
               upd.first_error = StInvalidSpacing;
            end else begin
               upd.last_was_space = (cp == 21'h20);
            end
         end
      end
   end

   always_comb begin
      result.code_points = upd.point_total;
      if (upd.byte_total >= ByteLimit) begin
         result.status = StTooLong;
      end else if (upd.first_error != StReady) begin
         result.status = upd.first_error;
      end else if (upd.bytes_pending != 2'd0) begin
         result.status = StInvalidUtf8;
      end else if (upd.last_was_space) begin
         result.status = StInvalidSpacing;
      end else begin
         result.status = StReady;
      end
      // A finished name starts the next one from scratch
      next_state = beat.last ? StateReset : upd;
   end

endmodule

>>> hw/rtl/utf8_name_validator.sv
// UTF-8 name validator.
// Bytes of a name enter on the req_ channel, one beat per byte, with the
// last flag set on the final byte. Each byte is decoded and checked against
// the UTF-8 rules, the code point limit held in the csr_ register, and the
// set of allowed characters and spacing. Only the final byte of a name
// produces a beat on the rsp_ channel: the status and the code point count.
// A final byte sits in the input register, then loads the result
// register once the result slot is free; rsp_valid is driven from the
// result register.
// Throughput: one byte per cycle, back to back, while the result register
// is free. Decode state advances from the input register, so the per-byte
// check is one shallow pass between two registers.
// When the receiver stalls, the result holds in its register; bytes that do
// not end a name keep flowing, and only a final byte waits behind a held
// result, which raises req_stall.
// Reset clears the name state, drops any held beats and loads the code point
// limit with 24. Write csr_ only while no name is in flight.
module utf8_name_validator
   import unv_pkg::*;
#(
   parameter int BUFFER_BYTES = BufferBytesDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_write_en,
   input  logic [PointWidth-1:0] csr_write_data
);

   // Input register
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;

   // Result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;

   name_state_type        state_ff;
   logic [PointWidth-1:0] max_points_ff;

   name_state_type  state_in;
   rsp_payload_type result;
   logic            out_free;
   logic            advance;
   logic            accept;

   unv_decode #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_decode (
      .cur_state      (state_ff),
      .beat           (in_data_ff),
      .max_code_points(max_points_ff),
      .next_state     (state_in),
      .result         (result)
   );

   // Advance the held byte unless it ends a name and the result slot is busy
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_data_ff.last || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && in_data_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= StateReset;
         max_points_ff <= MaxPointsReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_write_en) begin
            max_points_ff <= csr_write_data;
         end
      end
   end

   // Payload registers: load on accept / on a finished name
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance && in_data_ff.last) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hw/rtl/unv_checker.sv
module unv_checker
   import unv_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);

   // Hold a stalled result beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // Drop everything in flight on reset
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("beats survive reset");

   // Back-pressure only comes from a held result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while result path is free");

   // A ready name has at least one counted code point
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == StReady) |-> rsp_data.code_points != '0)
      else $error("ready status with no code points");

endmodule

bind utf8_name_validator unv_checker u_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import unv_pkg::*;

   // Clock period halves, drain margin past the result latency,
   // length of the one long receiver hold and the watchdog budget.
   localparam int HalfPeriod = 6;
   localparam int DrainCycles = 6;
   localparam int LongHoldCycles = 300;
   localparam int RunLimitNs = 5_000_000;

   typedef enum int {
      StallNone,
      StallRandom,
      StallPattern,
      StallHeavy
   } stall_style_type;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_data;
   logic            csr_write_en;
   logic [PointWidth-1:0] csr_write_data;

   utf8_name_validator u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #HalfPeriod clock = 1'b1;
      #HalfPeriod clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow of the validator: per-name decode state plus the point limit.
   // Every accepted byte advances it; a final byte queues the report that
   // the rsp_ channel must deliver.
   // ------------------------------------------------------------------
   logic [PointWidth-1:0]     point_limit;
   logic [ByteTotalWidth-1:0] nm_bytes;
   logic [PointWidth-1:0]     nm_points;
   logic [CodePointWidth-1:0] nm_partial;
   logic [1:0]                nm_pending;
   logic [1:0]                nm_seq_len;
   logic                      nm_prev_space;
   status_type                nm_error;

   rsp_payload_type pending_reports[$];
   int              fail_count = 0;
   int              sent_count = 0;

   function automatic void clear_name_state();
      nm_bytes      = '0;
      nm_points     = '0;
      nm_partial    = '0;
      nm_pending    = 2'd0;
      nm_seq_len    = 2'd0;
      nm_prev_space = 1'b1;
      nm_error      = StReady;
   endfunction

   function automatic bit is_name_char(logic [20:0] cp);
      return (cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A) ||
             (cp >= 21'h30 && cp <= 21'h39) || cp == 21'h20 || cp == 21'h2D ||
             cp == 21'h27 || (cp >= 21'hC0 && cp <= 21'hFF && cp != 21'hD7 &&
             cp != 21'hF7);
   endfunction

   // Judge one completed code point: range first, then the point limit,
   // then the character rules. Anything that passes range is counted
   // unless the limit is already reached.
   function automatic void close_point(logic [20:0] cp);
      logic [20:0] floor_cp;
      case (nm_seq_len)
         2'd1: floor_cp = 21'h80;
         2'd2: floor_cp = 21'h800;
         2'd3: floor_cp = 21'h10000;
         default: floor_cp = '0;
      endcase
      nm_seq_len = 2'd0;
      if (cp < floor_cp || cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF)) begin
         nm_error = StInvalidUtf8;
      end else if (nm_points >= point_limit) begin
         nm_error = StTooLong;
      end else begin
         nm_points = nm_points + 1'b1;
         if (cp >= 21'h300 && cp <= 21'h36F) begin
            nm_error = StNeedsNormalize;
         end else if (!is_name_char(cp)) begin
            nm_error = StUnsupported;
         end else if (cp == 21'h20 && nm_prev_space) begin
            nm_error = StInvalidSpacing;
         end else begin
            nm_prev_space = (cp == 21'h20);
         end
      end
   endfunction

   function automatic void decode_name_byte(logic [7:0] b, logic fin);
      status_type      st;
      rsp_payload_type report;
      if (nm_bytes != 8'hFF) nm_bytes = nm_bytes + 1'b1;
      // Once an error is recorded, only the byte count moves.
      if (nm_error == StReady) begin
         if (nm_pending == 2'd0) begin
            if (b < 8'h80) begin
               nm_seq_len = 2'd0;
               close_point({13'd0, b});
            end else if (b >= 8'hC2 && b <= 8'hDF) begin
               nm_partial = {16'd0, b[4:0]};
               nm_pending = 2'd1;
               nm_seq_len = 2'd1;
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
               nm_partial = {17'd0, b[3:0]};
               nm_pending = 2'd2;
               nm_seq_len = 2'd2;
            end else if (b >= 8'hF0 && b <= 8'hF4) begin
               nm_partial = {18'd0, b[2:0]};
               nm_pending = 2'd3;
               nm_seq_len = 2'd3;
            end else begin
               nm_error = StInvalidUtf8;
            end
         end else if (b[7:6] != 2'b10) begin
            nm_error = StInvalidUtf8;
         end else begin
            nm_partial = {nm_partial[14:0], b[5:0]};
            nm_pending = nm_pending - 1'b1;
            if (nm_pending == 2'd0) close_point(nm_partial);
         end
      end
      if (fin) begin
         // Buffer overflow outranks everything, then the first error,
         // then an unfinished sequence, then a trailing space.
         if (nm_bytes >= BufferBytesDefault) st = StTooLong;
         else if (nm_error != StReady) st = nm_error;
         else if (nm_pending != 2'd0) st = StInvalidUtf8;
         else if (nm_prev_space) st = StInvalidSpacing;
         else st = StReady;
         report.status = st;
         report.code_points = nm_points;
         pending_reports.push_back(report);
         clear_name_state();
      end
   endfunction

   // ------------------------------------------------------------------
   // Result side: stall on the selected style, with one long hold on
   // request, and compare every accepted beat with the oldest report.
   // ------------------------------------------------------------------
   stall_style_type stall_mode;
   bit              long_hold_req;
   bit              long_hold_done = 1'b0;

   initial begin : rsp_stall_driver
      int cyc;
      cyc = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req && !long_hold_done) begin
            // Hold off long enough that finals back up and req_stall rises.
            rsp_stall <= 1'b1;
            repeat (LongHoldCycles) @(posedge clock);
            long_hold_done = 1'b1;
         end
         cyc++;
         case (stall_mode)
            StallRandom:  rsp_stall <= ($urandom_range(0, 3) == 0);
            StallPattern: rsp_stall <= ((cyc % 9) < 4);
            StallHeavy:   rsp_stall <= ($urandom_range(0, 3) != 0);
            default:      rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin : check_reports
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            fail_count++;
            $error("status: no report expected, got %0d (code_points %0d)",
                   rsp_data.status, rsp_data.code_points);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_data.status !== want.status) begin
               fail_count++;
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
            end
            if (rsp_data.code_points !== want.code_points) begin
               fail_count++;
               $error("code_points: expected %0d, got %0d",
                      want.code_points, rsp_data.code_points);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Byte sender: bursts of random length with random gaps when enabled.
   // Every call starts and returns right after a rising edge.
   // ------------------------------------------------------------------
   bit sender_gaps;
   int burst_left;

   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (sender_gaps) begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= {b, fin};
      // Hold the beat until it is taken.
      do @(posedge clock); while (req_stall);
      decode_name_byte(b, fin);
      sent_count++;
   endtask

   // Drop valid, wait for every report, then let the pipeline settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_point_limit(input logic [PointWidth-1:0] limit);
      wait_drained();
      csr_write_en   <= 1'b1;
      csr_write_data <= limit;
      @(posedge clock);
      csr_write_en <= 1'b0;
      point_limit = limit;
   endtask

   // ------------------------------------------------------------------
   // Name builders: assemble bytes in name_buf, then send them as one name.
   // ------------------------------------------------------------------
   logic [7:0] name_buf[$];

   task automatic send_name();
      for (int i = 0; i < name_buf.size(); i++)
         send_byte(name_buf[i], i == name_buf.size() - 1);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   // Send the low n bytes of w, most significant first.
   task automatic send_word(input int n, input logic [31:0] w);
      for (int i = n - 1; i >= 0; i--) send_byte(w[8*i +: 8], i == 0);
   endtask

   // Encode cp in len bytes; a longer len than needed gives an overlong form.
   function automatic void push_point(logic [20:0] cp, int len);
      case (len)
         1: name_buf.push_back(cp[7:0]);
         2: begin
            name_buf.push_back({3'b110, cp[10:6]});
            name_buf.push_back({2'b10, cp[5:0]});
         end
         3: begin
            name_buf.push_back({4'b1110, cp[15:12]});
            name_buf.push_back({2'b10, cp[11:6]});
            name_buf.push_back({2'b10, cp[5:0]});
         end
         default: begin
            name_buf.push_back({5'b11110, cp[20:18]});
            name_buf.push_back({2'b10, cp[17:12]});
            name_buf.push_back({2'b10, cp[11:6]});
            name_buf.push_back({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   function automatic void push_char(logic [20:0] cp);
      if (cp < 21'h80) push_point(cp, 1);
      else if (cp < 21'h800) push_point(cp, 2);
      else if (cp < 21'h10000) push_point(cp, 3);
      else push_point(cp, 4);
   endfunction

   function automatic logic [20:0] pick_name_char();
      int          r;
      logic [20:0] cp;
      r = $urandom_range(0, 99);
      if (r < 40) return 21'(21'h61 + $urandom_range(0, 25));
      if (r < 60) return 21'(21'h41 + $urandom_range(0, 25));
      if (r < 68) return 21'(21'h30 + $urandom_range(0, 9));
      if (r < 72) return $urandom_range(0, 1) ? 21'h2D : 21'h27;
      do cp = 21'($urandom_range('hC0, 'hFF)); while (cp == 21'hD7 || cp == 21'hF7);
      return cp;
   endfunction

   function automatic logic [20:0] pick_any_point();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return pick_name_char();
      if (r < 52) return 21'h20;
      if (r < 60) return 21'($urandom_range(1, 'h7F));
      if (r < 72) return 21'($urandom_range('h80, 'h7FF));
      if (r < 80) return 21'($urandom_range('h300, 'h36F));
      if (r < 92) return 21'($urandom_range('h800, 'hFFFF));
      return 21'($urandom_range('h10000, 'h10FFFF));
   endfunction

   // Allowed characters with single interior spaces only.
   function automatic void build_clean_name(int n);
      bit prev_space;
      prev_space = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (i > 0 && i < n - 1 && !prev_space && $urandom_range(0, 6) == 0) begin
            name_buf.push_back(8'h20);
            prev_space = 1'b1;
         end else begin
            push_char(pick_name_char());
            prev_space = 1'b0;
         end
      end
   endfunction

   // Break a well-formed name in one of several ways.
   function automatic void corrupt_name();
      int pos;
      pos = $urandom_range(0, name_buf.size() - 1);
      case ($urandom_range(0, 5))
         0: name_buf[pos] = 8'($urandom_range(1, 255));
         1: if (name_buf.size() > 1) void'(name_buf.pop_back());
         2: name_buf.insert(pos, 8'($urandom_range('h80, 'hBF)));
         3: case ($urandom_range(0, 2))
               0: push_point(21'($urandom_range(1, 'h7F)), 2);
               1: push_point(21'($urandom_range(1, 'h7FF)), 3);
               default: push_point(21'($urandom_range(1, 'hFFFF)), 4);
            endcase
         4: push_point(21'($urandom_range('hD800, 'hDFFF)), 3);
         default: push_point(21'($urandom_range('h110000, 'h1FFFFF)), 4);
      endcase
      if ($urandom_range(0, 1)) name_buf.push_back(8'h61);
   endfunction

   task automatic send_random_name();
      int r;
      int lim;
      int n;
      lim = point_limit;
      r = $urandom_range(0, 99);
      n = $urandom_range(1, (lim < 11) ? lim + 1 : 12);
      name_buf.delete();
      if (r < 48) begin
         build_clean_name(n);
      end else if (r < 70) begin
         for (int i = 0; i < n; i++) push_char(pick_any_point());
      end else if (r < 82) begin
         build_clean_name(n);
         corrupt_name();
      end else if (r < 92) begin
         repeat ($urandom_range(1, 8)) name_buf.push_back(8'($urandom_range(1, 255)));
      end else if (r < 98) begin
         // Sit right around the point limit.
         build_clean_name($urandom_range((lim > 1) ? lim - 1 : 1, lim + 2));
      end else begin
         // Run past the byte buffer now and then.
         build_clean_name($urandom_range(100, 140));
      end
      send_name();
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed_cases();
      stall_mode  = StallNone;
      sender_gaps = 1'b0;
      send_word(1, 8'h01);          // lowest nonzero byte, unsupported control
      send_word(1, 8'hFF);          // highest byte, bad lead
      send_text(" a");              // leading space
      send_text("a ");              // trailing space
      send_text("a  ");             // doubled space
      send_text("z-'9");            // hyphen, apostrophe, digit: clean
      send_word(1, 8'h80);          // stray continuation
      send_word(2, 32'hC3A9);       // Latin-1 letter, clean
      send_word(1, 8'hC3);          // truncated sequence
      send_word(2, 32'hCC81);       // combining mark
      send_word(3, 32'hE08080);     // overlong three-byte form
      send_word(3, 32'hEDA080);     // surrogate
      send_word(4, 32'hF4908080);   // above the code space
      wait_drained();
   endtask

   task automatic test_point_limits();
      stall_mode  = StallRandom;
      sender_gaps = 1'b1;
      set_point_limit(6'd1);
      send_text("a");
      send_text("ab");
      send_word(2, 32'hC3A9);
      set_point_limit(6'd63);
      for (int n = 63; n <= 64; n++) begin
         name_buf.delete();
         repeat (n) name_buf.push_back(8'(8'h61 + $urandom_range(0, 25)));
         send_name();
      end
      // 63 two-byte letters fit; 64 of them fill the buffer.
      for (int n = 63; n <= 64; n++) begin
         name_buf.delete();
         repeat (n) push_char(21'(21'hE0 + $urandom_range(0, 22)));
         send_name();
      end
      set_point_limit(6'd7);
      send_text("abcdefg");
      send_text("abcdefgh");
      send_text("abc defg9");
   endtask

   task automatic test_buffer_overflow();
      stall_mode  = StallPattern;
      sender_gaps = 1'b0;
      set_point_limit(6'd63);
      // An early error with 127 and 128 bytes: only the longer one overflows.
      for (int n = 127; n <= 128; n++) begin
         name_buf.delete();
         name_buf.push_back(8'hFF);
         repeat (n - 1) name_buf.push_back(8'h61);
         send_name();
      end
      // Drive the byte count into saturation.
      name_buf.delete();
      repeat (300) name_buf.push_back(8'($urandom_range(1, 255)));
      send_name();
      wait_drained();
   endtask

   task automatic test_random_traffic();
      logic [PointWidth-1:0] limits[5];
      stall_style_type       styles[5];
      bit                    gaps[5];
      int                    target;
      limits = '{6'd24, 6'd1, 6'd63, 6'($urandom_range(2, 62)), 6'($urandom_range(1, 63))};
      styles = '{StallRandom, StallNone, StallPattern, StallHeavy, StallRandom};
      gaps   = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      for (int ph = 0; ph < 5; ph++) begin
         set_point_limit(limits[ph]);
         stall_mode  = styles[ph];
         sender_gaps = gaps[ph];
         target = sent_count + 165;
         while (sent_count < target) send_random_name();
      end
      wait_drained();
   endtask

   task automatic test_output_backpressure();
      stall_mode    = StallNone;
      sender_gaps   = 1'b0;
      long_hold_req = 1'b1;
      // Keep offering short names while the receiver holds off.
      repeat (60) begin
         name_buf.delete();
         build_clean_name($urandom_range(1, 2));
         send_name();
      end
      wait_drained();
      long_hold_req = 1'b0;
   endtask

   initial begin : watchdog
      #RunLimitNs;
      $display("utf8_name_validator verification failed");
      $finish;
   end

   initial begin : run_tests
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data       <= '0;
      csr_write_en   <= 1'b0;
      csr_write_data <= '0;
      stall_mode     = StallNone;
      sender_gaps    = 1'b0;
      long_hold_req  = 1'b0;
      burst_left     = 0;
      point_limit    = MaxPointsReset;
      clear_name_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_point_limits();
      test_buffer_overflow();
      test_random_traffic();
      test_output_backpressure();
      wait_drained();

      if (fail_count == 0) begin
         $display("utf8_name_validator verification clean");
      end else begin
         $display("utf8_name_validator verification failed");
      end
      $finish;
   end

endmodule
